[sv/jse_pkg.sv]
package jse_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] QUOTE_CH   = 8'h22;
	localparam logic [7:0] BSLASH_CH  = 8'h5C;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [7:0] U_CH       = 8'h75;
	localparam logic [7:0] ZERO_CH    = 8'h30;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_SHORT,
		KIND_UNI,
		KIND_EMPTY
	} esc_kind_t;

	// One classified input word: for a short escape the byte holds the escape letter.
	typedef struct packed {
		logic [7:0] data;
		esc_kind_t  kind;
		logic       open_q;
		logic       close_q;
	} desc_t;

	typedef struct packed {
		logic push;
	} q_wr_t;

	typedef struct packed {
		logic pop;
	} q_rd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h57 + {4'd0, nib};
		end
		return c;
	endfunction

	function automatic logic [2:0] body_len(input esc_kind_t kind);
		logic [2:0] n;
		case (kind)
			KIND_PLAIN: n = 3'd1;
			KIND_SHORT: n = 3'd2;
			KIND_UNI:   n = 3'd6;
			KIND_EMPTY: n = 3'd0;
			default:    n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

[sv/jse_if.sv]
interface jse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_first;
	logic       is_last;
	logic       has_byte;

	modport source (output valid, data_byte, is_first, is_last, has_byte, input ready);
	modport sink   (input valid, data_byte, is_first, is_last, has_byte, output ready);
endinterface

interface jse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_done;

	modport source (output valid, out_byte, run_last, string_done, input ready);
	modport sink   (input valid, out_byte, run_last, string_done, output ready);
endinterface

[sv/jse_front.sv]
module jse_front (
	jse_in_if.sink          din,
	output jse_pkg::q_wr_t  wr,
	input  logic            full,
	output jse_pkg::desc_t  desc
);

	assign din.ready = !full;
	assign wr.push   = din.valid && !full;

	always_comb begin
		desc.data    = din.data_byte;
		desc.kind    = jse_pkg::KIND_PLAIN;
		desc.open_q  = din.is_first;
		desc.close_q = din.is_last;
		if (!din.has_byte) begin
			desc.kind    = jse_pkg::KIND_EMPTY;
			desc.open_q  = 1'b1;
			desc.close_q = 1'b1;
		end else begin
			case (din.data_byte)
				8'h22: begin
					desc.kind = jse_pkg::KIND_SHORT;
					desc.data = jse_pkg::QUOTE_CH;
				end
				8'h5C: begin
					desc.kind = jse_pkg::KIND_SHORT;
					desc.data = jse_pkg::BSLASH_CH;
				end
				8'h0A: begin
					desc.kind = jse_pkg::KIND_SHORT;
					desc.data = 8'h6E;
				end
				8'h0D: begin
					desc.kind = jse_pkg::KIND_SHORT;
					desc.data = 8'h72;
				end
				8'h09: begin
					desc.kind = jse_pkg::KIND_SHORT;
					desc.data = 8'h74;
				end
				8'h08: begin
					desc.kind = jse_pkg::KIND_SHORT;
					desc.data = 8'h62;
				end
				8'h0C: begin
					desc.kind = jse_pkg::KIND_SHORT;
					desc.data = 8'h66;
				end
				default: begin
					if (din.data_byte < jse_pkg::CTRL_LIMIT) begin
						desc.kind = jse_pkg::KIND_UNI;
					end
				end
			endcase
		end
	end

endmodule

[sv/jse_queue.sv]
module jse_queue #(
	parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  jse_pkg::q_wr_t  wr,
	input  jse_pkg::desc_t  wr_desc,
	output logic            full,
	input  jse_pkg::q_rd_t  rd_in,
	output logic            rd_valid,
	output jse_pkg::desc_t  rd_desc
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jse_pkg::desc_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_desc  = mem_q[rd_ptr_q];
	assign do_pop   = rd_in.pop && rd_valid;

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr.push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/jse_back.sv]
module jse_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  jse_pkg::desc_t  q_desc,
	output jse_pkg::q_rd_t  rd,
	jse_out_if.source       dout
);

	logic [2:0] idx_q;
	logic [2:0] blen;
	logic [2:0] bidx;
	logic [3:0] total;
	logic [2:0] last_idx;
	logic [7:0] nxt_byte;
	logic       nxt_done;
	logic       nxt_last;
	logic       load;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       done_q;

	assign blen     = jse_pkg::body_len(q_desc.kind);
	assign total    = {3'd0, q_desc.open_q} + {1'b0, blen} + {3'd0, q_desc.close_q};
	assign last_idx = 3'(total - 4'd1);
	assign bidx     = idx_q - {2'd0, q_desc.open_q};
	assign nxt_last = (idx_q == last_idx);
	assign load     = q_valid && (!valid_q || dout.ready);

	assign rd.pop   = load && nxt_last;

	always_comb begin
		nxt_byte = jse_pkg::QUOTE_CH;
		nxt_done = 1'b0;
		if (q_desc.open_q && idx_q == 3'd0) begin
			nxt_byte = jse_pkg::QUOTE_CH;
		end else if (bidx < blen) begin
			case (q_desc.kind)
				jse_pkg::KIND_SHORT: begin
					nxt_byte = (bidx == 3'd0) ? jse_pkg::BSLASH_CH : q_desc.data;
				end
				jse_pkg::KIND_UNI: begin
					case (bidx)
						3'd0:    nxt_byte = jse_pkg::BSLASH_CH;
						3'd1:    nxt_byte = jse_pkg::U_CH;
						3'd2:    nxt_byte = jse_pkg::ZERO_CH;
						3'd3:    nxt_byte = jse_pkg::ZERO_CH;
						3'd4:    nxt_byte = jse_pkg::hex_char(q_desc.data[7:4]);
						default: nxt_byte = jse_pkg::hex_char(q_desc.data[3:0]);
					endcase
				end
				default: nxt_byte = q_desc.data;
			endcase
		end else begin
			nxt_byte = jse_pkg::QUOTE_CH;
			nxt_done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= nxt_last ? 3'd0 : idx_q + 3'd1;
			end else if (dout.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= nxt_byte;
			last_q <= nxt_last;
			done_q <= nxt_done;
		end
	end

	assign dout.valid       = valid_q;
	assign dout.out_byte    = byte_q;
	assign dout.run_last    = last_q;
	assign dout.string_done = done_q;

endmodule

[sv/json_string_escaper.sv]
// JSON string escaper. Raw string bytes enter on din, one word per byte, each marked
// as the first and/or last of its string; a word without a byte stands for an empty
// string. The quoted, escaped text leaves on dout one byte per word, with run_last on
// the final byte caused by an input word and string_done on each closing quote.
// An input word is classified on arrival and written into a small queue; the back end
// reads the head of the queue and emits its run of one to eight bytes, one byte per
// cycle while the output register is empty or being read, into an output register.
// A word whose run is one byte long sustains one word per cycle while dout.ready stays
// high; a longer run occupies the back end until its last byte is loaded, and the
// input stalls once the queue is full.
// Reset empties the queue and clears the output valid flag, leaving both channels idle.
// When the receiver holds ready low the output byte is held, the back end stops, and
// the queue absorbs input until it fills, after which din.ready falls.
module json_string_escaper #(
	parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	jse_in_if.sink      din,
	jse_out_if.source   dout
);

	jse_pkg::q_wr_t  wr;
	jse_pkg::q_rd_t  rd;
	jse_pkg::desc_t  wr_desc;
	jse_pkg::desc_t  rd_desc;
	logic            full;
	logic            rd_valid;

	jse_front u_front (
		.din  (din),
		.wr   (wr),
		.full (full),
		.desc (wr_desc)
	);

	jse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_desc  (wr_desc),
		.full     (full),
		.rd_in    (rd),
		.rd_valid (rd_valid),
		.rd_desc  (rd_desc)
	);

	jse_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (rd_valid),
		.q_desc  (rd_desc),
		.rd      (rd),
		.dout    (dout)
	);

endmodule

[tb/sv/tb_json_string_escaper.sv]
module tb_json_string_escaper;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] BS_CH  = 8'h08;
	localparam logic [7:0] TAB_CH = 8'h09;
	localparam logic [7:0] LF_CH  = 8'h0A;
	localparam logic [7:0] FF_CH  = 8'h0C;
	localparam logic [7:0] CR_CH  = 8'h0D;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_done;
	} json_byte_t;

	class escape_scoreboard;
		json_byte_t pending_bytes[$];
		int         words_noted;
		int         bytes_checked;
		int         strings_closed;
		int         failures;

		function int pending();
			return pending_bytes.size();
		endfunction

		// Works out the quoted, escaped run that one accepted word must produce.
		function void note_word(logic [7:0] d, logic f, logic l, logic h);
			json_byte_t run[$];
			logic [7:0] letter;
			string      digits;
			digits = "0123456789abcdef";
			letter = 8'h00;
			if (!h) begin
				run.push_back('{jse_pkg::QUOTE_CH, 1'b0, 1'b0});
				run.push_back('{jse_pkg::QUOTE_CH, 1'b0, 1'b1});
			end else begin
				if (f) begin
					run.push_back('{jse_pkg::QUOTE_CH, 1'b0, 1'b0});
				end
				case (d)
					jse_pkg::QUOTE_CH:  letter = jse_pkg::QUOTE_CH;
					jse_pkg::BSLASH_CH: letter = jse_pkg::BSLASH_CH;
					LF_CH:              letter = "n";
					CR_CH:              letter = "r";
					TAB_CH:             letter = "t";
					BS_CH:              letter = "b";
					FF_CH:              letter = "f";
					default:            letter = 8'h00;
				endcase
				if (letter != 8'h00) begin
					run.push_back('{jse_pkg::BSLASH_CH, 1'b0, 1'b0});
					run.push_back('{letter, 1'b0, 1'b0});
				end else if (d < jse_pkg::CTRL_LIMIT) begin
					run.push_back('{jse_pkg::BSLASH_CH, 1'b0, 1'b0});
					run.push_back('{jse_pkg::U_CH, 1'b0, 1'b0});
					run.push_back('{jse_pkg::ZERO_CH, 1'b0, 1'b0});
					run.push_back('{jse_pkg::ZERO_CH, 1'b0, 1'b0});
					run.push_back('{8'(digits[d[7:4]]), 1'b0, 1'b0});
					run.push_back('{8'(digits[d[3:0]]), 1'b0, 1'b0});
				end else begin
					run.push_back('{d, 1'b0, 1'b0});
				end
				if (l) begin
					run.push_back('{jse_pkg::QUOTE_CH, 1'b0, 1'b1});
				end
			end
			run[run.size() - 1].run_last = 1'b1;
			foreach (run[k]) begin
				pending_bytes.push_back(run[k]);
			end
			words_noted++;
		endfunction

		function void check_byte(json_byte_t got);
			json_byte_t want;
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected byte %h run_last %b string_done %b", $time,
					got.out_byte, got.run_last, got.string_done);
				failures++;
				return;
			end
			want = pending_bytes.pop_front();
			if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
					got.string_done !== want.string_done) begin
				$display("%0t: mismatch, expected byte %h run_last %b string_done %b, got %h %b %b",
					$time, want.out_byte, want.run_last, want.string_done,
					got.out_byte, got.run_last, got.string_done);
				failures++;
			end
			bytes_checked++;
			if (got.string_done === 1'b1) begin
				strings_closed++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle;
	int   recv_idle;

	escape_scoreboard sb;

	jse_in_if  din();
	jse_out_if dout();

	json_string_escaper i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	initial begin
		#1ms;
		$display("tb_json_string_escaper: done, errors");
		$finish;
	end

	task automatic send_word(input logic [7:0] d, input logic f, input logic l, input logic h);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			din.valid = 1'b0;
			@(negedge clk);
		end
		din.valid     = 1'b1;
		din.data_byte = d;
		din.is_first  = f;
		din.is_last   = l;
		din.has_byte  = h;
		do begin
			@(posedge clk);
		end while (din.ready !== 1'b1);
		sb.note_word(d, f, l, h);
	endtask

	task automatic drain();
		@(negedge clk);
		din.valid = 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// Mostly whole or empty strings with random content; about one call in ten sends a stray word.
	task automatic send_random_string();
		int         len;
		logic [7:0] d;
		if ($urandom_range(0, 9) == 0) begin
			send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			return;
		end
		len = $urandom_range(0, 6);
		if (len == 0) begin
			send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'b0);
		end
		for (int k = 0; k < len; k++) begin
			case ($urandom_range(0, 7))
				0, 1:    d = 8'($urandom_range(0, 31));
				2:       d = ($urandom_range(0, 1) != 0) ? jse_pkg::QUOTE_CH : jse_pkg::BSLASH_CH;
				default: d = 8'($urandom_range(0, 255));
			endcase
			send_word(d, k == 0, k == len - 1, 1'b1);
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			dout.ready = ($urandom_range(0, 99) >= recv_idle);
			@(posedge clk);
			if (arst_n && dout.valid === 1'b1 && dout.ready === 1'b1) begin
				sb.check_byte('{dout.out_byte, dout.run_last, dout.string_done});
			end
		end
	end

	initial begin
		int phase_start;
		sb            = new();
		send_idle     = 7;
		recv_idle     = 53;
		arst_n        = 1'b0;
		din.valid     = 1'b0;
		din.data_byte = 8'h00;
		din.is_first  = 1'b0;
		din.is_last   = 1'b0;
		din.has_byte  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_word(8'h00, 1'b1, 1'b1, 1'b1);
		send_word(8'hFF, 1'b1, 1'b1, 1'b1);
		send_word(8'h5A, 1'b0, 1'b0, 1'b0);
		send_word(8'hA5, 1'b1, 1'b1, 1'b0);
		send_word(8'h3C, 1'b1, 1'b0, 1'b0);
		send_word(jse_pkg::QUOTE_CH, 1'b1, 1'b0, 1'b1);
		send_word(jse_pkg::BSLASH_CH, 1'b0, 1'b0, 1'b1);
		send_word(LF_CH, 1'b0, 1'b0, 1'b1);
		send_word(CR_CH, 1'b0, 1'b0, 1'b1);
		send_word(TAB_CH, 1'b0, 1'b0, 1'b1);
		send_word(BS_CH, 1'b0, 1'b0, 1'b1);
		send_word(FF_CH, 1'b0, 1'b0, 1'b1);
		send_word(8'h1F, 1'b0, 1'b0, 1'b1);
		send_word(8'h10, 1'b0, 1'b0, 1'b1);
		send_word(8'h20, 1'b0, 1'b0, 1'b1);
		send_word(8'h7F, 1'b0, 1'b0, 1'b1);
		send_word(8'h80, 1'b0, 1'b0, 1'b1);
		send_word(8'hC3, 1'b0, 1'b0, 1'b1);
		send_word(8'hA9, 1'b0, 1'b1, 1'b1);
		send_word(8'h01, 1'b0, 1'b1, 1'b1);
		drain();

		for (int p = 0; p < 3; p++) begin
			send_idle   = (p == 0) ? 7 : (p == 1) ? 53 : 0;
			recv_idle   = (p == 0) ? 53 : (p == 1) ? 7 : 0;
			phase_start = sb.words_noted;
			while (sb.words_noted - phase_start < 26) begin
				send_random_string();
			end
			drain();
		end

		repeat (10) @(posedge clk);
		$display("%0d input words sent as strings, stray words and empty strings;",
			sb.words_noted);
		$display("%0d output bytes checked, %0d closing quotes seen.", sb.bytes_checked,
			sb.strings_closed);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("tb_json_string_escaper: done, clean");
		end else begin
			$display("tb_json_string_escaper: done, errors");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/jse_pkg.sv
sv/jse_if.sv
sv/jse_front.sv
sv/jse_queue.sv
sv/jse_back.sv
sv/json_string_escaper.sv
tb/sv/tb_json_string_escaper.sv
